FILE: rtl/she_pkg.sv
// Shared types and constants for the stereo harmonic exciter.
package she_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int Q30_SHIFT   = 31 - SAMPLE_BITS;
  localparam int CFG_BITS    = 17;
  localparam int NUM_BITS    = 48;
  localparam int QUO_BITS    = 31;

  typedef enum logic [2:0] {
    REG_POLE       = 3'd0,
    REG_CLIP_GAIN  = 3'd1,
    REG_HARM       = 3'd2,
    REG_MIX_GAIN   = 3'd3,
    REG_ACCUMULATE = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;
    logic signed [SAMPLE_BITS-1:0] prior_left;
    logic signed [SAMPLE_BITS-1:0] prior_right;
    logic                          block_end;
  } frame_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic                          block_end_out;
  } result_t;

endpackage

FILE: rtl/stereo_harmonic_exciter.sv
// Stereo harmonic exciter: high-pass, clip, waveshape, high-pass, mix.
//
// Input channel: frame_valid / frame_stall carry one stereo frame per beat
// in frame. A beat is taken when frame_valid is high and frame_stall low.
// Output channel: result_valid / result_stall carry one result per frame.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// in the same cycle; write only while the block is idle.
// Each channel runs through one shared 33x19 multiplier and a one bit per
// cycle divider in 13 sequencer steps plus a wait on the divider; the left
// channel runs first, then the right, and a new frame is taken only after
// the result has been passed to the output register.
// frame_stall stays high during that work. The finished result sits in an
// output register, so the next frame is taken while it waits; if the
// receiver still stalls when the next result is done, the sequencer holds.
// Reset clears all four filter states and loads the register defaults.
module stereo_harmonic_exciter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             frame_valid,
  output logic                             frame_stall,
  input  she_pkg::frame_t                  frame,
  output logic                             result_valid,
  input  logic                             result_stall,
  output she_pkg::result_t                 result,
  input  logic                             cfg_write,
  input  logic [2:0]                       cfg_index,
  input  logic [she_pkg::CFG_BITS-1:0]     cfg_data
);

  localparam int SB = she_pkg::SAMPLE_BITS;
  localparam int SH = she_pkg::Q30_SHIFT;
  localparam int NB = she_pkg::NUM_BITS;
  localparam int QB = she_pkg::QUO_BITS;

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001, ST_M1 = 16'h0002, ST_M2 = 16'h0004, ST_F1 = 16'h0008,
    ST_M3   = 16'h0010, ST_CL = 16'h0020, ST_M4 = 16'h0040, ST_M5 = 16'h0080,
    ST_DV0  = 16'h0100, ST_DIV = 16'h0200, ST_M6 = 16'h0400, ST_M7 = 16'h0800,
    ST_F2   = 16'h1000, ST_M8 = 16'h2000, ST_FIN = 16'h4000, ST_PUB = 16'h8000
  } state_t;

  state_t state;
  logic   ch;
  she_pkg::frame_t frame_r;

  logic [15:0] pole;
  logic [15:0] clip_gain;
  logic [16:0] harm_amount;
  logic [15:0] mix_gain;
  logic        accumulate;

  logic signed [31:0] lp1 [2];
  logic signed [31:0] lp2 [2];

  logic signed [51:0] prod;
  logic signed [51:0] acc;
  logic signed [32:0] hp;
  logic signed [32:0] s_reg;
  logic               neg;
  logic [30:0]        mag;
  logic [NB-1:0]      num;
  logic signed [SB-1:0] out_l;
  logic signed [SB-1:0] osat_r;

  logic signed [SB-1:0] xs;
  logic signed [SB-1:0] ps;
  logic signed [32:0]   x30;
  logic signed [32:0]   ma;
  logic signed [18:0]   mb;
  logic signed [18:0]   one_minus_p;
  logic signed [32:0]   fx;
  logic signed [53:0]   fsum;
  logic signed [53:0]   fr;
  logic signed [31:0]   fy;
  logic signed [51:0]   ct;
  logic signed [31:0]   cv;
  logic signed [53:0]   w;
  logic signed [53:0]   wet;
  logic signed [53:0]   osum;
  logic signed [SB-1:0] osat;

  logic [QB-1:0] quo;
  logic          div_done;
  logic          div_start;
  logic [NB-1:0] den;

  assign frame_stall = (state != ST_IDLE);
  assign div_start   = (state == ST_DV0);
  assign den         = NB'(prod[NB-1:0]) + (NB'(1) << 38);

  always_comb begin
    xs          = ch ? frame_r.in_right : frame_r.in_left;
    ps          = ch ? frame_r.prior_right : frame_r.prior_left;
    x30         = 33'(xs) <<< SH;
    one_minus_p = 19'sd65536 - signed'({3'b000, pole});
    ma = '0;
    mb = '0;
    unique case (state)
      ST_M1:   begin ma = x30;   mb = one_minus_p; end
      ST_M2:   begin ma = 33'(lp1[ch]); mb = signed'({3'b000, pole}); end
      ST_M3:   begin ma = hp;    mb = signed'({3'b000, clip_gain}); end
      ST_M4:   begin
        ma = signed'({2'b00, mag});
        mb = signed'({2'b00, harm_amount}) + 19'sd256;
      end
      ST_M5:   begin ma = signed'({2'b00, mag}); mb = signed'({2'b00, harm_amount}); end
      ST_M6:   begin ma = s_reg; mb = one_minus_p; end
      ST_M7:   begin ma = 33'(lp2[ch]); mb = signed'({3'b000, pole}); end
      ST_M8:   begin ma = hp;    mb = signed'({3'b000, mix_gain}); end
      default: begin ma = '0;    mb = '0; end
    endcase
  end

  always_comb begin
    fx   = (state == ST_F2) ? s_reg : x30;
    fsum = 54'(acc) + 54'(prod) + 54'sd32768;
    fr   = fsum >>> 16;
    if (fr > 54'sd2147483647) begin
      fy = 32'sh7fffffff;
    end else if (fr < -54'sd2147483648) begin
      fy = 32'sh80000000;
    end else begin
      fy = fr[31:0];
    end
    ct = (prod + 52'sd2048) >>> 12;
    if (ct > 52'sd1073741824) begin
      cv = 32'sd1073741824;
    end else if (ct < -52'sd1073741824) begin
      cv = -32'sd1073741824;
    end else begin
      cv = ct[31:0];
    end
    w    = (54'(prod) + 54'sd8192) >>> 14;
    wet  = (w + (54'sd1 <<< (SH - 1))) >>> SH;
    osum = 54'(xs) + wet + (accumulate ? 54'(ps) : 54'sd0);
    if (osum > 54'((64'sd1 <<< (SB - 1)) - 1)) begin
      osat = {1'b0, {(SB-1){1'b1}}};
    end else if (osum < -54'(64'sd1 <<< (SB - 1))) begin
      osat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      osat = osum[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pole        <= 16'd24170;
      clip_gain   <= 16'd4096;
      harm_amount <= 17'd0;
      mix_gain    <= 16'd8192;
      accumulate  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        she_pkg::REG_POLE:       pole        <= cfg_data[15:0];
        she_pkg::REG_CLIP_GAIN:  clip_gain   <= cfg_data[15:0];
        she_pkg::REG_HARM:       harm_amount <= cfg_data[16:0];
        she_pkg::REG_MIX_GAIN:   mix_gain    <= cfg_data[15:0];
        she_pkg::REG_ACCUMULATE: accumulate  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= 52'(ma * mb);
    if (state == ST_M2 || state == ST_M7) acc <= prod;
    if (state == ST_F1 || state == ST_F2) hp <= fx - 33'(fy);
    if (state == ST_CL) begin
      neg <= cv[31];
      mag <= cv[31] ? 31'(-cv) : cv[30:0];
    end
    if (state == ST_M5) num <= prod[NB-1:0];
    if (state == ST_DIV && div_done) begin
      s_reg <= neg ? -33'(signed'({2'b00, quo})) : 33'(signed'({2'b00, quo}));
    end
    if (state == ST_FIN && !ch) out_l <= osat;
    if (state == ST_IDLE && frame_valid) frame_r <= frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ch           <= 1'b0;
      result_valid <= 1'b0;
      lp1[0] <= '0;
      lp1[1] <= '0;
      lp2[0] <= '0;
      lp2[1] <= '0;
    end else begin
      if (result_valid && !result_stall && state != ST_PUB) result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (frame_valid) begin
          ch    <= 1'b0;
          state <= ST_M1;
        end
        ST_M1:  state <= ST_M2;
        ST_M2:  state <= ST_F1;
        ST_F1:  begin lp1[ch] <= fy; state <= ST_M3; end
        ST_M3:  state <= ST_CL;
        ST_CL:  state <= ST_M4;
        ST_M4:  state <= ST_M5;
        ST_M5:  state <= ST_DV0;
        ST_DV0: state <= ST_DIV;
        ST_DIV: if (div_done) state <= ST_M6;
        ST_M6:  state <= ST_M7;
        ST_M7:  state <= ST_F2;
        ST_F2:  begin lp2[ch] <= fy; state <= ST_M8; end
        ST_M8:  state <= ST_FIN;
        ST_FIN: begin
          if (ch) begin
            state <= ST_PUB;
          end else begin
            ch    <= 1'b1;
            state <= ST_M1;
          end
        end
        ST_PUB: if (!result_valid || !result_stall) begin
          result.out_left      <= out_l;
          result.out_right     <= osat_r;
          result.block_end_out <= frame_r.block_end;
          result_valid         <= 1'b1;
          state                <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && ch) osat_r <= osat;
  end

  she_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .quo   (quo),
    .done  (div_done)
  );

`ifndef NO_ASSERTIONS
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && !frame_stall) |=> (state == ST_M1 && !ch))
    else $error("accepted frame did not start left channel");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV) else $error("divider result outside wait step");
  a_publish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUB && !(result_valid && result_stall)) |=>
    (result_valid && state == ST_IDLE)) else $error("result not published");
  a_lp_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_F1) |=> $stable(lp1[0]) && $stable(lp1[1]))
    else $error("first filter state changed outside update");
`endif

endmodule

FILE: rtl/she_div.sv
// Restoring divider for the waveshaper, one quotient bit per cycle.
module she_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [she_pkg::NUM_BITS-1:0]    num,
  input  logic [she_pkg::NUM_BITS-1:0]    den,
  output logic [she_pkg::QUO_BITS-1:0]    quo,
  output logic                            done
);

  localparam int NB = she_pkg::NUM_BITS;
  localparam int QB = she_pkg::QUO_BITS;

  logic [NB:0]   rem;
  logic [NB-1:0] dreg;
  logic [4:0]    cnt;
  logic          busy;
  logic [NB:0]   trial;
  logic          take;

  always_comb begin
    trial = (cnt == 5'd0) ? rem : {rem[NB-1:0], 1'b0};
    take  = trial >= {1'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= {1'b0, num};
        dreg <= den;
        quo  <= '0;
      end else if (busy) begin
        rem <= take ? trial - {1'b0, dreg} : trial;
        quo <= {quo[QB-2:0], take};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(QB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("divider started while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("divider done while busy");
  a_done_after: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without work");
`endif

endmodule
